// File: sv/rms_pkg.sv
`timescale 1ns / 1ps

package rms_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 17;
    localparam int SUM_W    = 33;
    localparam int SQ_W     = 47;
    localparam int MEAN_W   = 24;
    localparam int SD_W     = 24;

    localparam logic [CNT_W-1:0] MAX_SAMPLES = CNT_W'(65536);

    // report datapath widths
    localparam int PROD_W   = 64;
    localparam int LO_W     = 24;
    localparam int HI_W     = SQ_W - LO_W;
    localparam int DIFF_W   = 62;
    localparam int FRAC_W   = 16;
    localparam int DVD_W    = DIFF_W + FRAC_W;
    localparam int DVS_W    = 32;
    localparam int MAG_W    = SUM_W - 1;

    // microcode
    localparam int PC_W     = 4;
    localparam int ITC_W    = 7;
    localparam logic [PC_W-1:0]  PC_LAST    = PC_W'(11);
    localparam logic [ITC_W-1:0] DIV_LAST   = ITC_W'(DVD_W - 1);
    localparam logic [ITC_W-1:0] SQRT_LAST  = ITC_W'(PROD_W / 2 - 1);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REPORT = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ADD_HI,
        OP_SQ,
        OP_DVS_M,
        OP_SUB,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_MEAN_INIT,
        OP_FIN
    } t_op;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_LOOP,
        JC_END
    } t_jc;

    typedef struct packed {
        t_op              op;
        t_jc              jc;
        logic             cnt_ld;
        logic [ITC_W-1:0] cnt_val;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic add;
        logic clr;
    } t_ctl;

endpackage

// File: sv/running_mean_stddev.sv
`timescale 1ns / 1ps

// Running mean and sample standard deviation of signed 16-bit samples.
// A request is taken when start is high and busy is low. Add-sample and clear
// requests complete in the cycle they are taken and never raise busy, so samples
// go in at one per clock while no report runs. A report request raises busy
// while a microcoded sequencer steps the shared datapath: four multiplies (two
// of them partial products), a bit-serial divide for the variance, an integer
// square root and a second bit-serial divide for the mean. The result appears in
// the cycle in which busy falls, with o_valid high for exactly one cycle; it
// cannot be held off and must be captured then. Mean is signed Q8 truncated
// toward zero, deviation unsigned Q8 floored. A sample offered when the count is
// full is dropped and sets a sticky flag, reported on o_saturated, until a clear.

module running_mean_stddev import rms_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_req_type,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_valid,
    output logic signed [MEAN_W-1:0]   o_mean_q8,
    output logic [SD_W-1:0]            o_sd_q8,
    output logic [CNT_W-1:0]           o_sample_count,
    output logic                       o_saturated
);

    t_ctl w_ctl;

    rms_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .o_busy     (busy),
        .o_ctl      (w_ctl)
    );

    rms_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .o_mean_q8      (o_mean_q8),
        .o_sd_q8        (o_sd_q8),
        .o_sample_count (o_sample_count),
        .o_saturated    (o_saturated)
    );

endmodule

// File: sv/rms_ucode.sv
`timescale 1ns / 1ps

module rms_ucode import rms_pkg::*; (
    input  logic [PC_W-1:0] i_pc,
    output t_uword          o_uw
);

    localparam logic [PC_W-1:0] STEP_MUL_LO    = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_MUL_HI    = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_ADD_HI    = PC_W'(2);
    localparam logic [PC_W-1:0] STEP_SQ        = PC_W'(3);
    localparam logic [PC_W-1:0] STEP_DVS_M     = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_SUB       = PC_W'(5);
    localparam logic [PC_W-1:0] STEP_VAR_DIV   = PC_W'(6);
    localparam logic [PC_W-1:0] STEP_SQRT_INIT = PC_W'(7);
    localparam logic [PC_W-1:0] STEP_SQRT      = PC_W'(8);
    localparam logic [PC_W-1:0] STEP_MEAN_INIT = PC_W'(9);
    localparam logic [PC_W-1:0] STEP_MEAN_DIV  = PC_W'(10);
    localparam logic [PC_W-1:0] STEP_FIN       = PC_W'(11);

    always_comb begin
        o_uw.op      = OP_NOP;
        o_uw.jc      = JC_END;
        o_uw.cnt_ld  = 1'b0;
        o_uw.cnt_val = '0;
        case (i_pc)
            STEP_MUL_LO: begin
                o_uw.op = OP_MUL_LO;
                o_uw.jc = JC_NEXT;
            end
            STEP_MUL_HI: begin
                o_uw.op = OP_MUL_HI;
                o_uw.jc = JC_NEXT;
            end
            STEP_ADD_HI: begin
                o_uw.op = OP_ADD_HI;
                o_uw.jc = JC_NEXT;
            end
            STEP_SQ: begin
                o_uw.op = OP_SQ;
                o_uw.jc = JC_NEXT;
            end
            STEP_DVS_M: begin
                o_uw.op = OP_DVS_M;
                o_uw.jc = JC_NEXT;
            end
            STEP_SUB: begin
                o_uw.op      = OP_SUB;
                o_uw.jc      = JC_NEXT;
                o_uw.cnt_ld  = 1'b1;
                o_uw.cnt_val = DIV_LAST;
            end
            STEP_VAR_DIV: begin
                o_uw.op = OP_DIV_STEP;
                o_uw.jc = JC_LOOP;
            end
            STEP_SQRT_INIT: begin
                o_uw.op      = OP_SQRT_INIT;
                o_uw.jc      = JC_NEXT;
                o_uw.cnt_ld  = 1'b1;
                o_uw.cnt_val = SQRT_LAST;
            end
            STEP_SQRT: begin
                o_uw.op = OP_SQRT_STEP;
                o_uw.jc = JC_LOOP;
            end
            STEP_MEAN_INIT: begin
                o_uw.op      = OP_MEAN_INIT;
                o_uw.jc      = JC_NEXT;
                o_uw.cnt_ld  = 1'b1;
                o_uw.cnt_val = DIV_LAST;
            end
            STEP_MEAN_DIV: begin
                o_uw.op = OP_DIV_STEP;
                o_uw.jc = JC_LOOP;
            end
            STEP_FIN: begin
                o_uw.op = OP_FIN;
                o_uw.jc = JC_END;
            end
            default: begin
                o_uw.op = OP_NOP;
                o_uw.jc = JC_END;
            end
        endcase
    end

endmodule

// File: sv/rms_seq.sv
`timescale 1ns / 1ps

module rms_seq import rms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_req_type,
    output logic       o_busy,
    output t_ctl       o_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [ITC_W-1:0] r_cnt, n_cnt;
    t_uword           w_uw;

    rms_ucode u_ucode (
        .i_pc (r_pc),
        .o_uw (w_uw)
    );

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_cnt     = r_cnt;
        o_ctl.op  = OP_NOP;
        o_ctl.add = 1'b0;
        o_ctl.clr = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (t_req'(i_req_type))
                        REQ_ADD:   o_ctl.add = 1'b1;
                        REQ_CLEAR: o_ctl.clr = 1'b1;
                        REQ_REPORT: begin
                            n_state = ST_RUN;
                            n_pc    = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_ctl.op = w_uw.op;
                if (w_uw.cnt_ld) begin
                    n_cnt = w_uw.cnt_val;
                end
                case (w_uw.jc)
                    JC_NEXT: n_pc = r_pc + PC_W'(1);
                    JC_LOOP: begin
                        // stay on this step until the iteration count runs out
                        if (r_cnt != '0) begin
                            n_cnt = r_cnt - ITC_W'(1);
                        end else begin
                            n_pc = r_pc + PC_W'(1);
                        end
                    end
                    JC_END: begin
                        n_state = ST_IDLE;
                        n_pc    = '0;
                    end
                    default: begin
                        n_state = ST_IDLE;
                        n_pc    = '0;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
                n_pc    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state == ST_RUN);

    a_report_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req_type == REQ_REPORT) |=> o_busy)
        else $error("report request did not start the program");

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (r_pc <= PC_LAST))
        else $error("step counter left the program");

    a_no_accum_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !(o_ctl.add || o_ctl.clr))
        else $error("accumulator request issued while busy");

endmodule

// File: sv/rms_dpath.sv
`timescale 1ns / 1ps

module rms_dpath import rms_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctl                       i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_valid,
    output logic signed [MEAN_W-1:0]   o_mean_q8,
    output logic [SD_W-1:0]            o_sd_q8,
    output logic [CNT_W-1:0]           o_sample_count,
    output logic                       o_saturated
);

    // accumulators
    logic [CNT_W-1:0]          r_count;
    logic [SUM_W-1:0]          r_sum;
    logic [SQ_W-1:0]           r_sumsq;
    logic                      r_ovf;
    logic [2*SAMPLE_W-1:0]     r_sq;
    logic                      r_sq_vld;

    // report datapath
    logic [PROD_W-1:0]         r_a;
    logic [PROD_W-1:0]         r_b;
    logic [DVD_W-1:0]          r_dvd;
    logic [DVS_W-1:0]          r_rem;
    logic [DVS_W-1:0]          r_dvs;
    logic [PROD_W-1:0]         r_v;
    logic [PROD_W-1:0]         r_res;
    logic [PROD_W-1:0]         r_bit;

    logic                      r_done;
    logic [MEAN_W-1:0]         r_mean;
    logic [SD_W-1:0]           r_sd;
    logic [CNT_W-1:0]          r_cnt_o;
    logic                      r_sat_o;

    logic signed [2*SAMPLE_W-1:0] w_samp_sq;
    logic [SUM_W-1:0]          w_sum_neg;
    logic [MAG_W-1:0]          w_sm;
    logic [CNT_W+LO_W-1:0]     w_mlo;
    logic [CNT_W+HI_W-1:0]     w_mhi;
    logic [2*MAG_W-1:0]        w_sm_sq;
    logic [2*CNT_W-1:0]        w_m;
    logic [PROD_W-1:0]         w_diff;
    logic [DVS_W:0]            w_rem_sh;
    logic [DVS_W:0]            w_rem_diff;
    logic                      w_qbit;
    logic [PROD_W-1:0]         w_trial;
    logic                      w_ge;
    logic [MEAN_W-1:0]         w_q;

    assign w_samp_sq  = i_sample_value * i_sample_value;
    assign w_sum_neg  = SUM_W'(0) - r_sum;
    assign w_sm       = r_sum[SUM_W-1] ? w_sum_neg[MAG_W-1:0] : r_sum[MAG_W-1:0];
    assign w_mlo      = r_count * r_sumsq[LO_W-1:0];
    assign w_mhi      = r_count * r_sumsq[SQ_W-1:LO_W];
    assign w_sm_sq    = w_sm * w_sm;
    assign w_m        = r_count * (r_count - CNT_W'(1));
    // spread is never negative, clamp anyway
    assign w_diff     = (r_a > r_b) ? (r_a - r_b) : '0;
    assign w_rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_dvs};
    assign w_qbit     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_trial    = r_res + r_bit;
    assign w_ge       = (r_v >= w_trial);
    assign w_q        = r_dvd[MEAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_sumsq  <= '0;
            r_ovf    <= 1'b0;
            r_sq_vld <= 1'b0;
        end else if (i_ctl.clr) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_sumsq  <= '0;
            r_ovf    <= 1'b0;
            r_sq_vld <= 1'b0;
        end else begin
            // square lands in the sum of squares in the cycle after its sample
            if (r_sq_vld) begin
                r_sumsq <= r_sumsq + SQ_W'(r_sq);
            end
            r_sq_vld <= 1'b0;
            if (i_ctl.add) begin
                if (r_count == MAX_SAMPLES) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count  <= r_count + CNT_W'(1);
                    r_sum    <= r_sum + {{(SUM_W-SAMPLE_W){i_sample_value[SAMPLE_W-1]}},
                                         i_sample_value};
                    r_sq_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.add) begin
            r_sq <= w_samp_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_MUL_LO: r_a <= PROD_W'(w_mlo);
            OP_MUL_HI: r_b <= PROD_W'(w_mhi);
            OP_ADD_HI: r_a <= r_a + {r_b[PROD_W-LO_W-1:0], {LO_W{1'b0}}};
            OP_SQ:     r_b <= PROD_W'(w_sm_sq);
            OP_DVS_M:  r_dvs <= w_m[DVS_W-1:0];
            OP_SUB: begin
                r_dvd <= {w_diff[DIFF_W-1:0], {FRAC_W{1'b0}}};
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= w_qbit ? w_rem_diff[DVS_W-1:0] : w_rem_sh[DVS_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], w_qbit};
            end
            OP_SQRT_INIT: begin
                r_v   <= r_dvd[PROD_W-1:0];
                r_res <= '0;
                r_bit <= PROD_W'(1) << (PROD_W - 2);
            end
            OP_SQRT_STEP: begin
                if (w_ge) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_MEAN_INIT: begin
                r_dvd <= DVD_W'({w_sm, 8'b0});
                r_dvs <= DVS_W'(r_count);
                r_rem <= '0;
            end
            OP_FIN: begin
                if (r_count == '0) begin
                    r_mean <= '0;
                end else if (r_sum[SUM_W-1]) begin
                    r_mean <= MEAN_W'(0) - w_q;
                end else begin
                    r_mean <= w_q;
                end
                r_sd    <= (r_count < CNT_W'(2)) ? '0 : r_res[SD_W-1:0];
                r_cnt_o <= r_count;
                r_sat_o <= r_ovf;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_ctl.op == OP_FIN);
        end
    end

    assign o_valid        = r_done;
    assign o_mean_q8      = r_mean;
    assign o_sd_q8        = r_sd;
    assign o_sample_count = r_cnt_o;
    assign o_saturated    = r_sat_o;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_SAMPLES)
        else $error("sample count beyond limit");

    a_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.add && !i_ctl.clr && r_count == MAX_SAMPLES) |=> (r_ovf && $stable(r_count)))
        else $error("sample on full count was not dropped");

endmodule

// File: dv/running_mean_stddev_checker.sv
`timescale 1ns / 1ps

module running_mean_stddev_checker import rms_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [1:0]                 i_req_type,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_valid,
    input  logic signed [MEAN_W-1:0]   i_mean_q8,
    input  logic [SD_W-1:0]            i_sd_q8,
    input  logic [CNT_W-1:0]           i_sample_count,
    input  logic                       i_saturated,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_compared
);

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [SD_W-1:0]   sd;
        logic [CNT_W-1:0]  cnt;
        logic              sat;
    } t_stats;

    // shadow accumulators
    logic [CNT_W-1:0]        acc_count = '0;
    logic signed [SUM_W-1:0] acc_sum   = '0;
    logic [SQ_W-1:0]         acc_sumsq = '0;
    logic                    acc_sat   = 1'b0;

    t_stats pending_stats[$];
    t_stats got;
    t_stats want;

    int n_errors   = 0;
    int n_pending  = 0;
    int n_compared = 0;

    assign o_errors   = n_errors;
    assign o_pending  = n_pending;
    assign o_compared = n_compared;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = v;
        root  = '0;
        probe = 64'h1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic t_stats predict_stats();
        longint signed s;
        longint signed mean;
        logic [63:0] n;
        logic [63:0] mag;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] var_q16;
        logic [63:0] sd;
        t_stats res;
        s    = acc_sum;
        n    = 64'(acc_count);
        mean = 0;
        sd   = '0;
        // signed division truncates toward zero
        if (n != 0)
            mean = (s * 64'sd256) / $signed(n);
        if (n > 1) begin
            mag = (s < 0) ? 64'(-s) : 64'(s);
            a   = n * 64'(acc_sumsq);
            b   = mag * mag;
            d   = (a > b) ? a - b : 64'd0;
            m   = n * (n - 64'd1);
            q   = d / m;
            r   = d % m;
            // split divide keeps the Q16 fraction exact
            var_q16 = (q << 16) + ((r << 16) / m);
            sd  = int_sqrt(var_q16);
        end
        res.mean = mean[MEAN_W-1:0];
        res.sd   = sd[SD_W-1:0];
        res.cnt  = acc_count;
        res.sat  = acc_sat;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch %s at %0t: expected 0x%0h got 0x%0h",
                         name, $realtime, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        longint signed v;
        if (!i_rst_n) begin
            acc_count = '0;
            acc_sum   = '0;
            acc_sumsq = '0;
            acc_sat   = 1'b0;
            pending_stats.delete();
        end else begin
            if (i_valid) begin
                if (pending_stats.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result at %0t with no report pending",
                                 $realtime);
                end else begin
                    want = pending_stats.pop_front();
                    got.mean = i_mean_q8;
                    got.sd   = i_sd_q8;
                    got.cnt  = i_sample_count;
                    got.sat  = i_saturated;
                    check_field("mean_q8", 64'(want.mean), 64'(got.mean));
                    check_field("sd_q8", 64'(want.sd), 64'(got.sd));
                    check_field("sample_count", 64'(want.cnt), 64'(got.cnt));
                    check_field("saturated", 64'(want.sat), 64'(got.sat));
                    n_compared++;
                end
            end
            if (i_start && !i_busy) begin
                case (i_req_type)
                    REQ_ADD: begin
                        if (acc_count >= MAX_SAMPLES) begin
                            acc_sat = 1'b1;
                        end else begin
                            v = i_sample_value;
                            acc_count = acc_count + 1'b1;
                            acc_sum   = acc_sum + SUM_W'(v);
                            acc_sumsq = acc_sumsq + SQ_W'(v * v);
                        end
                    end
                    REQ_REPORT: begin
                        pending_stats.push_back(predict_stats());
                    end
                    REQ_CLEAR: begin
                        acc_count = '0;
                        acc_sum   = '0;
                        acc_sumsq = '0;
                        acc_sat   = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        n_pending = pending_stats.size();
    end

endmodule

// File: dv/running_mean_stddev_tb.sv
`timescale 1ns / 1ps

module running_mean_stddev_tb;

    import rms_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RAND_ITEMS   = 350;
    localparam int DRAIN_CYCLES = 256;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;

    logic                       i_clk;
    logic                       i_rst_n  = 1'b0;
    logic                       r_start  = 1'b0;
    logic [1:0]                 r_req    = REQ_ADD;
    logic signed [SAMPLE_W-1:0] r_sample = '0;

    logic                       w_busy;
    logic                       w_valid;
    logic signed [MEAN_W-1:0]   w_mean;
    logic [SD_W-1:0]            w_sd;
    logic [CNT_W-1:0]           w_count;
    logic                       w_sat;

    int w_errors;
    int w_pending;
    int w_compared;

    int idle_pct     = 0;
    int cluster_base = 0;
    int n_adds       = 0;
    int n_reports    = 0;
    int n_clears     = 0;
    int n_unused     = 0;

    running_mean_stddev DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (r_start),
        .busy           (w_busy),
        .i_req_type     (r_req),
        .i_sample_value (r_sample),
        .o_valid        (w_valid),
        .o_mean_q8      (w_mean),
        .o_sd_q8        (w_sd),
        .o_sample_count (w_count),
        .o_saturated    (w_sat)
    );

    running_mean_stddev_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (r_start),
        .i_busy         (w_busy),
        .i_req_type     (r_req),
        .i_sample_value (r_sample),
        .i_valid        (w_valid),
        .i_mean_q8      (w_mean),
        .i_sd_q8        (w_sd),
        .i_sample_count (w_count),
        .i_saturated    (w_sat),
        .o_errors       (w_errors),
        .o_pending      (w_pending),
        .o_compared     (w_compared)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results still pending", w_pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // one request, held until the block takes it
    task automatic send_req(input logic [1:0] req, input logic signed [SAMPLE_W-1:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            r_start  <= 1'b0;
            r_req    <= 2'($urandom);
            r_sample <= SAMPLE_W'($urandom);
            @(posedge i_clk);
        end
        r_start  <= 1'b1;
        r_req    <= req;
        r_sample <= val;
        @(posedge i_clk);
        while (w_busy)
            @(posedge i_clk);
        case (req)
            REQ_ADD:    n_adds++;
            REQ_REPORT: n_reports++;
            REQ_CLEAR:  n_clears++;
            default:    n_unused++;
        endcase
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return SAMPLE_W'($urandom);
        if (pick < 70) begin
            case ($urandom_range(0, 4))
                0:       return S_MIN;
                1:       return S_MAX;
                2:       return '0;
                3:       return -16'sd1;
                default: return 16'sd1;
            endcase
        end
        // tight cluster so the deviation is small against the mean
        v = cluster_base + int'($urandom_range(0, 255)) - 128;
        return SAMPLE_W'(v);
    endfunction

    task automatic send_random(input int n);
        int sent;
        int pick;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                send_req(REQ_ADD, rand_sample());
                sent++;
            end else if (pick < 93) begin
                send_req(REQ_REPORT, SAMPLE_W'($urandom));
                sent++;
            end else if (pick < 97) begin
                cluster_base = int'($urandom_range(0, 65535)) - 32768;
                send_req(REQ_CLEAR, SAMPLE_W'($urandom));
                sent++;
            end else begin
                send_req(REQ_UNUSED, SAMPLE_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 18;
        // empty, single sample, widest pair
        send_req(REQ_REPORT, S_MAX);
        send_req(REQ_ADD, S_MAX);
        send_req(REQ_REPORT, '0);
        send_req(REQ_ADD, S_MIN);
        send_req(REQ_REPORT, '0);
        send_req(REQ_UNUSED, S_MIN);
        send_req(REQ_REPORT, '0);
        send_req(REQ_CLEAR, S_MAX);
        send_req(REQ_REPORT, '0);
        send_req(REQ_ADD, '0);
        send_req(REQ_ADD, -16'sd1);
        send_req(REQ_ADD, 16'sd1);
        send_req(REQ_REPORT, '0);
        send_req(REQ_REPORT, '0);
        send_req(REQ_CLEAR, '0);
        // identical samples give zero spread
        send_req(REQ_ADD, S_MAX);
        send_req(REQ_ADD, S_MAX);
        send_req(REQ_ADD, S_MAX);
        send_req(REQ_REPORT, '0);
        send_req(REQ_CLEAR, '0);
        send_req(REQ_ADD, S_MIN);
        send_req(REQ_ADD, 16'sh5555);
        send_req(REQ_ADD, -16'sh2aab);
        send_req(REQ_REPORT, '0);
        send_req(REQ_CLEAR, '0);

        send_random(RAND_ITEMS);

        idle_pct = 79;
        send_random(RAND_ITEMS);

        idle_pct = 0;
        send_random(RAND_ITEMS);

        r_start <= 1'b0;
        while (w_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d samples, %0d reports, %0d clears, %0d unused; %0d results compared",
                 n_adds, n_reports, n_clears, n_unused, w_compared);
        $display("directed edge cases then random traffic; sender idled 18%%, 79%%, then never");
        if (w_errors == 0 && w_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", w_errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/rms_pkg.sv
sv/rms_ucode.sv
sv/rms_seq.sv
sv/rms_dpath.sv
sv/running_mean_stddev.sv
dv/running_mean_stddev_checker.sv
dv/running_mean_stddev_tb.sv
